// ----- hdl/sagf_pkg.sv -----
// Shared types, constants and the step function of the source-address gate filter.
package sagf_pkg;

	// Length of the rotate-XOR cell row.
	localparam int unsigned MAX_STEPS = 14;

	// Width of the steps count that travels with each item.
	localparam int unsigned STEPS_W = 4;
	localparam logic [STEPS_W-1:0] STEPS_SAT = {STEPS_W{1'b1}};
	localparam logic [STEPS_W-1:0] STEPS_GIVE_UP =
		(MAX_STEPS > 15) ? STEPS_SAT : STEPS_W'(MAX_STEPS);

	localparam logic [13:0] HDR_BYTES = 14'd54;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
	localparam logic [15:0] STEP_MUL = 16'h1337;

	localparam logic [15:0] W1_REF = 16'h03BF;
	localparam logic [7:0] W3_HI_REF = 8'h2B;
	localparam logic [7:0] W4_HI_REF = 8'h2F;
	localparam logic [15:0] W6_REF = 16'h039F;
	localparam logic [7:0] W7_LO_REF = 8'hFF;

	localparam logic [7:0] POINT_MIN = 8'd1;
	localparam logic [7:0] POINT_MAX = 8'd7;

	// Cause codes
	localparam logic [2:0] CAUSE_BYPASS = 3'd0;
	localparam logic [2:0] CAUSE_ERRSUM = 3'd1;
	localparam logic [2:0] CAUSE_POINT = 3'd2;
	localparam logic [2:0] CAUSE_EQUAL = 3'd3;
	localparam logic [2:0] CAUSE_MATCHED = 3'd4;
	localparam logic [2:0] CAUSE_DIVERGED = 3'd5;

	localparam int unsigned N_SQ = 9;

	// One item on its way down the cell row.
	typedef struct packed {
		logic done;
		logic [2:0] cause;
		logic [STEPS_W-1:0] steps;
		logic [15:0] x;
		logic [15:0] tgt;
		logic [15:0] c;
	} token_t;

	function automatic logic [15:0] sagf_step(input logic [15:0] x, input logic [15:0] c);
		logic [15:0] rl1;
		logic [15:0] rl3;
		logic [15:0] rr2;
		rl1 = {x[14:0], x[15]};
		rl3 = {x[12:0], x[15:13]};
		rr2 = {x[1:0], x[15:2]};
		return rl1 ^ rl3 ^ rr2 ^ c;
	endfunction

	function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- hdl/sagf_front.sv -----
// Header checks, squared-error gate, point gate and start-equals-target check ahead of the cell row.
module sagf_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [13:0] frame_length,
	input  logic [15:0] ether_type,
	input  logic [15:0] addr_word0,
	input  logic [15:0] addr_word1,
	input  logic [15:0] addr_word2,
	input  logic [15:0] addr_word3,
	input  logic [15:0] addr_word4,
	input  logic [15:0] addr_word5,
	input  logic [15:0] addr_word6,
	input  logic [15:0] addr_word7,
	output logic out_valid,
	input  logic out_ready,
	output sagf_pkg::token_t out_tok
);
	import sagf_pkg::*;

	logic [7:0] p0, p3, p4, p7;
	logic [7:0] d_a, d_b, d_c, d_f, d_g, d_i;
	logic [15:0] d_e, d_h;
	logic [31:0] sq [N_SQ];

	logic valid_s1, valid_s2;
	logic ready_s1, ready_s2;
	logic bypass_s1;
	logic [7:0] p0_s1;
	logic [15:0] x_s1, tgt_s1, c_s1;
	logic [31:0] sq_s1 [N_SQ];
	logic [31:0] err;
	token_t tok_d, tok_s2;

	assign p0 = addr_word0[15:8];
	assign p3 = addr_word3[7:0];
	assign p4 = addr_word4[7:0];
	assign p7 = addr_word7[15:8];

	// Squares of wrapped differences equal squares of their magnitudes mod 2^32.
	assign d_a = abs_diff8(p0, p3);
	assign d_b = abs_diff8(p3, p4);
	assign d_c = abs_diff8(p4, p7);
	assign d_e = abs_diff16(addr_word1, W1_REF);
	assign d_f = abs_diff8(addr_word3[15:8], W3_HI_REF);
	assign d_g = abs_diff8(addr_word4[15:8], W4_HI_REF);
	assign d_h = abs_diff16(addr_word6, W6_REF);
	assign d_i = abs_diff8(addr_word7[7:0], W7_LO_REF);

	always_comb begin
		sq[0] = {16'd0, 16'(d_a * d_a)};
		sq[1] = {16'd0, 16'(d_b * d_b)};
		sq[2] = {16'd0, 16'(d_c * d_c)};
		sq[3] = {16'd0, 16'(addr_word0[7:0] * addr_word0[7:0])};
		sq[4] = 32'(d_e * d_e);
		sq[5] = {16'(d_f * d_f), 16'd0};
		sq[6] = {16'(d_g * d_g), 16'd0};
		sq[7] = 32'(d_h * d_h);
		sq[8] = {16'd0, 16'(d_i * d_i)};
	end

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			bypass_s1 <= (frame_length < HDR_BYTES) || (ether_type != ETYPE_IPV6);
			p0_s1 <= p0;
			x_s1 <= addr_word2;
			tgt_s1 <= addr_word5;
			c_s1 <= 16'({8'd0, p0} * STEP_MUL);
			sq_s1 <= sq;
		end
	end

	always_comb begin
		err = 32'd0;
		for (int i = 0; i < N_SQ; i++) begin
			err = err + sq_s1[i];
		end
	end

	always_comb begin
		tok_d.done = 1'b1;
		tok_d.cause = CAUSE_BYPASS;
		tok_d.steps = '0;
		tok_d.x = x_s1;
		tok_d.tgt = tgt_s1;
		tok_d.c = c_s1;
		priority if (bypass_s1) begin
			tok_d.cause = CAUSE_BYPASS;
		end else if (err != 32'd0) begin
			tok_d.cause = CAUSE_ERRSUM;
		end else if (p0_s1 < POINT_MIN || p0_s1 > POINT_MAX) begin
			tok_d.cause = CAUSE_POINT;
		end else if (x_s1 == tgt_s1) begin
			tok_d.cause = CAUSE_EQUAL;
		end else begin
			tok_d.done = 1'b0;
			tok_d.cause = CAUSE_DIVERGED;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			tok_s2 <= tok_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_tok = tok_s2;

endmodule

// ----- hdl/sagf_cell.sv -----
// One rotate-XOR step cell with its own stage register.
module sagf_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sagf_pkg::token_t in_tok,
	input  logic [sagf_pkg::STEPS_W-1:0] step_num,
	output logic out_valid,
	input  logic out_ready,
	output sagf_pkg::token_t out_tok
);
	import sagf_pkg::*;

	logic valid_q;
	logic [15:0] nx;
	token_t tok_d, tok_q;

	assign nx = sagf_step(in_tok.x, in_tok.c);

	// Advance only items still searching; hold finished ones unchanged.
	always_comb begin
		tok_d = in_tok;
		if (!in_tok.done) begin
			tok_d.x = nx;
			if (nx == in_tok.tgt) begin
				tok_d.done = 1'b1;
				tok_d.cause = CAUSE_MATCHED;
				tok_d.steps = step_num;
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_q <= tok_d;
		end
	end

	assign out_valid = valid_q;
	assign out_tok = tok_q;

endmodule

// ----- hdl/ipv6_source_address_gate_filter.sv -----
// Top level of the IPv6 source-address gate filter: front checks and the step cell row.
// Pass/drop filter for one frame header per item. An item carries the frame length,
// the Ethernet type and the eight little-endian source-address words; the result item
// carries verdict (1 = drop), cause and the number of rotate-XOR steps used. A frame
// shorter than 54 bytes or not IPv6 passes with cause 0. Otherwise a 32-bit wrapping
// squared-error sum must be zero, the point byte must lie in 1..7, and word 2 is
// stepped toward word 5 by a row of MAX_STEPS cells, one step per cell. The block
// takes one item per cycle while the output is not stalled. An item passes through
// the two front stages (squares, then the error sum) and the one register in each
// step cell. Every stage has its own valid bit, so a stalled output only backs up
// the stages that are full.
module ipv6_source_address_gate_filter (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// frame_length[13:0], ether_type[29:14], addr_word0..7 [45:30]..[157:142], zero pad
	input  logic [159:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// verdict[0], cause[3:1], steps_used[7:4]
	output logic [7:0] m_axis_tdata
);
	import sagf_pkg::*;

	logic v [MAX_STEPS+1];
	logic r [MAX_STEPS+1];
	token_t tok [MAX_STEPS+1];
	token_t last_tok;
	logic [2:0] cause;
	logic [STEPS_W-1:0] steps_used;
	logic verdict;

	// Front: bypass check, error gate, point gate, start-equals-target check.
	sagf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.frame_length (s_axis_tdata[13:0]),
		.ether_type   (s_axis_tdata[29:14]),
		.addr_word0   (s_axis_tdata[45:30]),
		.addr_word1   (s_axis_tdata[61:46]),
		.addr_word2   (s_axis_tdata[77:62]),
		.addr_word3   (s_axis_tdata[93:78]),
		.addr_word4   (s_axis_tdata[109:94]),
		.addr_word5   (s_axis_tdata[125:110]),
		.addr_word6   (s_axis_tdata[141:126]),
		.addr_word7   (s_axis_tdata[157:142]),
		.out_valid    (v[0]),
		.out_ready    (r[0]),
		.out_tok      (tok[0])
	);

	// Cell row: cell k applies step k and records k (saturated) on a match.
	for (genvar k = 1; k <= MAX_STEPS; k++) begin : g_cell
		localparam logic [STEPS_W-1:0] NUM = (k > 15) ? STEPS_SAT : STEPS_W'(k);
		sagf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[k-1]),
			.in_ready  (r[k-1]),
			.in_tok    (tok[k-1]),
			.step_num  (NUM),
			.out_valid (v[k]),
			.out_ready (r[k]),
			.out_tok   (tok[k])
		);
	end

	assign last_tok = tok[MAX_STEPS];
	assign m_axis_tvalid = v[MAX_STEPS];
	assign r[MAX_STEPS] = m_axis_tready;

	// An item still searching after the last cell has diverged.
	assign cause = last_tok.done ? last_tok.cause : CAUSE_DIVERGED;
	assign steps_used = last_tok.done ? last_tok.steps : STEPS_GIVE_UP;
	assign verdict = (cause == CAUSE_ERRSUM) || (cause == CAUSE_POINT) ||
		(cause == CAUSE_DIVERGED);

	assign m_axis_tdata = {steps_used, cause, verdict};

endmodule

// ----- bench/tb_ipv6_source_address_gate_filter.sv -----
// Self-checking stream testbench for the IPv6 source-address gate filter.
`timescale 1ns / 100ps

module tb_ipv6_source_address_gate_filter;
	import sagf_pkg::*;

	localparam logic VERDICT_PASS = 1'b0;
	localparam logic VERDICT_DROP = 1'b1;

	localparam int unsigned LATENCY = MAX_STEPS + 2;
	localparam int unsigned RANDOM_ITEMS = 830;
	localparam int unsigned CALM_ITEMS = 100;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	// One frame header as it travels on the input stream, first field lowest.
	typedef struct packed {
		logic [7:0][15:0] addr;
		logic [15:0] ether_type;
		logic [13:0] frame_length;
	} frame_hdr_t;

	// One verdict as it travels on the output stream, first field lowest.
	typedef struct packed {
		logic [STEPS_W-1:0] steps_used;
		logic [2:0] cause;
		logic verdict;
	} gate_result_t;

	// A header on offer, with a hand-written verdict where one is given.
	typedef struct packed {
		frame_hdr_t hdr;
		logic has_want;
		gate_result_t want;
	} frame_offer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [159:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	// No idling on either side once this is set.
	logic calm = 1'b0;

	frame_offer_t directed_rows[$];
	frame_offer_t offered[$];
	gate_result_t pending_results[$];
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;

	frame_offer_t accepted_offer;
	gate_result_t got_result;
	gate_result_t want_result;
	logic moved;

	always #6 clk = ~clk;

	ipv6_source_address_gate_filter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// One rotate-XOR step on a 16-bit word.
	function automatic logic [15:0] mix_step(input logic [15:0] x, input logic [15:0] c);
		return ((x << 1) | (x >> 15)) ^ ((x << 3) | (x >> 13)) ^ ((x >> 2) | (x << 14)) ^ c;
	endfunction

	// Walk a start word n steps for a given point.
	function automatic logic [15:0] advance_word(input logic [15:0] start,
			input logic [7:0] point, input int unsigned n);
		logic [15:0] x;
		logic [15:0] c;
		x = start;
		c = point * STEP_MUL;
		for (int unsigned k = 0; k < n; k++)
			x = mix_step(x, c);
		return x;
	endfunction

	function automatic logic [31:0] square_wrap(input logic [31:0] v);
		return v * v;
	endfunction

	// Expected verdict for one header.
	function automatic gate_result_t predict_gate(input frame_hdr_t h);
		logic [31:0] p0;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p7;
		logic [31:0] err;
		logic [15:0] x;
		logic [15:0] c;
		int unsigned steps;
		gate_result_t r;
		r = '0;
		r.verdict = VERDICT_PASS;
		r.cause = CAUSE_BYPASS;
		if (h.frame_length < HDR_BYTES || h.ether_type != ETYPE_IPV6)
			return r;
		p0 = 32'(h.addr[0][15:8]);
		p3 = 32'(h.addr[3][7:0]);
		p4 = 32'(h.addr[4][7:0]);
		p7 = 32'(h.addr[7][15:8]);
		err = square_wrap(p0 - p3) + square_wrap(p3 - p4) + square_wrap(p4 - p7);
		err += square_wrap(32'(h.addr[0][7:0]));
		err += square_wrap(32'(h.addr[1]) - 32'(W1_REF));
		err += square_wrap(32'({h.addr[3][15:8], 8'h00}) - 32'({W3_HI_REF, 8'h00}));
		err += square_wrap(32'({h.addr[4][15:8], 8'h00}) - 32'({W4_HI_REF, 8'h00}));
		err += square_wrap(32'(h.addr[6]) - 32'(W6_REF));
		err += square_wrap(32'(h.addr[7][7:0]) - 32'(W7_LO_REF));
		if (err != 0) begin
			r.verdict = VERDICT_DROP;
			r.cause = CAUSE_ERRSUM;
		end else if (p0 < POINT_MIN || p0 > POINT_MAX) begin
			r.verdict = VERDICT_DROP;
			r.cause = CAUSE_POINT;
		end else begin
			c = 16'(p0 * STEP_MUL);
			x = h.addr[2];
			if (x == h.addr[5]) begin
				r.cause = CAUSE_EQUAL;
			end else begin
				// Assume divergence, then look for the first match.
				r.verdict = VERDICT_DROP;
				r.cause = CAUSE_DIVERGED;
				steps = MAX_STEPS;
				for (int unsigned k = 1; k <= MAX_STEPS; k++) begin
					x = mix_step(x, c);
					if (x == h.addr[5]) begin
						r.verdict = VERDICT_PASS;
						r.cause = CAUSE_MATCHED;
						steps = k;
						break;
					end
				end
				r.steps_used = (steps > 15) ? 4'hF : steps[3:0];
			end
		end
		return r;
	endfunction

	// A minimal-length IPv6 header whose error sum is zero.
	function automatic frame_hdr_t good_frame(input logic [7:0] point,
			input logic [15:0] start, input logic [15:0] target);
		frame_hdr_t h;
		h.frame_length = HDR_BYTES;
		h.ether_type = ETYPE_IPV6;
		h.addr[0] = {point, 8'h00};
		h.addr[1] = W1_REF;
		h.addr[2] = start;
		h.addr[3] = {W3_HI_REF, point};
		h.addr[4] = {W4_HI_REF, point};
		h.addr[5] = target;
		h.addr[6] = W6_REF;
		h.addr[7] = {point, W7_LO_REF};
		return h;
	endfunction

	// Mostly well-formed headers with random content, plus broken and raw noise.
	function automatic frame_hdr_t random_frame();
		frame_hdr_t h;
		logic [7:0] point;
		logic [15:0] start;
		logic [15:0] target;
		int unsigned pick;
		int unsigned w;
		pick = $urandom_range(0, 99);
		point = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 7)) : 8'($urandom_range(0, 255));
		start = 16'($urandom);
		case ($urandom_range(0, 3))
			0: target = start;
			1, 2: target = advance_word(start, point, $urandom_range(1, MAX_STEPS));
			default: target = 16'($urandom);
		endcase
		h = good_frame(point, start, target);
		if ($urandom_range(0, 7) != 0)
			h.frame_length = 14'($urandom_range(HDR_BYTES, 16383));
		if (pick >= 65 && pick < 77) begin
			// Flip one bit of a word that the error sum pins down.
			w = $urandom_range(0, 5);
			w = w + (w > 1) + (w > 3);
			h.addr[w] = h.addr[w] ^ (16'h0001 << $urandom_range(0, 15));
		end else if (pick >= 77 && pick < 87) begin
			if ($urandom_range(0, 1))
				h.frame_length = 14'($urandom_range(0, HDR_BYTES - 1));
			else
				h.ether_type = 16'($urandom);
		end else if (pick >= 87) begin
			for (int i = 0; i < 8; i++)
				h.addr[i] = 16'($urandom);
			h.frame_length = 14'($urandom);
			h.ether_type = 16'($urandom);
			if ($urandom_range(0, 1)) begin
				h.ether_type = ETYPE_IPV6;
				h.frame_length = 14'($urandom_range(HDR_BYTES, 16383));
			end
		end
		return h;
	endfunction

	task automatic add_row(input frame_hdr_t h, input logic has_want, input logic verdict,
			input logic [2:0] cause);
		frame_offer_t row;
		row.hdr = h;
		row.has_want = has_want;
		row.want = '0;
		row.want.verdict = verdict;
		row.want.cause = cause;
		directed_rows.push_back(row);
	endtask

	// Present one header; hold it until the block takes it.
	task automatic offer_frame(input frame_offer_t ofr);
		int unsigned gap;
		if (!calm && $urandom_range(0, 99) < 18) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		offered.push_back(ofr);
		s_axis_tdata <= {2'b00, ofr.hdr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Output side: stall in random bursts until the calm tail.
	initial begin
		int unsigned burst;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 99) < 82) begin
				m_axis_tready <= 1'b1;
			end else begin
				burst = $urandom_range(1, 16);
				m_axis_tready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end
		end
	end

	// Sample both handshakes at the rising edge: queue expectations, check results.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (s_axis_tvalid && s_axis_tready) begin
				accepted_offer = offered.pop_front();
				pending_results.push_back(accepted_offer.has_want ? accepted_offer.want
					: predict_gate(accepted_offer.hdr));
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_result = gate_result_t'(m_axis_tdata);
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: verdict %0d cause %0d steps %0d",
							got_result.verdict, got_result.cause, got_result.steps_used);
					mismatch_count++;
				end else begin
					want_result = pending_results.pop_front();
					if (got_result.verdict !== want_result.verdict ||
							got_result.cause !== want_result.cause ||
							got_result.steps_used !== want_result.steps_used) begin
						if (mismatch_count < 10)
							$display("mismatch: verdict %0d/%0d cause %0d/%0d steps %0d/%0d (exp/got)",
								want_result.verdict, got_result.verdict,
								want_result.cause, got_result.cause,
								want_result.steps_used, got_result.steps_used);
						mismatch_count++;
					end
				end
			end
			// Watchdog: end the run if nothing moves for too long.
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_ipv6_source_address_gate_filter NOT OK");
				$finish;
			end
		end
	end

	initial begin
		frame_hdr_t h;
		frame_offer_t ofr;

		// Bypass: short, not IPv6, one byte below the header length, near miss on type.
		h = '0;
		add_row(h, 1'b1, VERDICT_PASS, CAUSE_BYPASS);
		h = '1;
		add_row(h, 1'b1, VERDICT_PASS, CAUSE_BYPASS);
		h = good_frame(8'd3, 16'h1234, 16'h1234);
		h.frame_length = HDR_BYTES - 1;
		add_row(h, 1'b1, VERDICT_PASS, CAUSE_BYPASS);
		h = good_frame(8'd3, 16'h1234, 16'h1234);
		h.ether_type = ETYPE_IPV6 ^ 16'h0001;
		add_row(h, 1'b1, VERDICT_PASS, CAUSE_BYPASS);

		// Start equals target, at the minimum and maximum length.
		add_row(good_frame(8'd3, 16'hA5A5, 16'hA5A5), 1'b1, VERDICT_PASS, CAUSE_EQUAL);
		h = good_frame(8'd7, 16'hFFFF, 16'hFFFF);
		h.frame_length = '1;
		add_row(h, 1'b1, VERDICT_PASS, CAUSE_EQUAL);

		// Error sum on all-zero and all-ones address words.
		h = '0;
		h.frame_length = HDR_BYTES;
		h.ether_type = ETYPE_IPV6;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = '1;
		h.ether_type = ETYPE_IPV6;
		add_row(h, 1'b0, VERDICT_PASS, CAUSE_BYPASS);

		// Point byte out of range, both sides.
		add_row(good_frame(8'd0, 16'h0001, 16'h0002), 1'b1, VERDICT_DROP, CAUSE_POINT);
		add_row(good_frame(8'd8, 16'h0001, 16'h0002), 1'b1, VERDICT_DROP, CAUSE_POINT);
		add_row(good_frame(8'hFF, 16'h0001, 16'h0002), 1'b1, VERDICT_DROP, CAUSE_POINT);

		// Matches after one step, after seven steps and after the last step, and likely divergence.
		add_row(good_frame(8'd1, 16'h0001, advance_word(16'h0001, 8'd1, 1)),
			1'b0, VERDICT_PASS, CAUSE_BYPASS);
		add_row(good_frame(8'd7, 16'h0000, advance_word(16'h0000, 8'd7, MAX_STEPS)),
			1'b0, VERDICT_PASS, CAUSE_BYPASS);
		add_row(good_frame(8'd4, 16'hFFFF, advance_word(16'hFFFF, 8'd4, MAX_STEPS + 1)),
			1'b0, VERDICT_PASS, CAUSE_BYPASS);
		add_row(good_frame(8'd2, 16'h8000, 16'h7FFF), 1'b0, VERDICT_PASS, CAUSE_BYPASS);
		add_row(good_frame(8'd5, 16'h5A5A, advance_word(16'h5A5A, 8'd5, 7)),
			1'b0, VERDICT_PASS, CAUSE_BYPASS);

		// Break one pinned field at a time; each leaves a small nonzero error sum.
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[0][7:0] = 8'h01;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[1] = W1_REF ^ 16'h0001;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[3][15:8] = W3_HI_REF + 8'd1;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[4][15:8] = W4_HI_REF - 8'd1;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[6] = W6_REF + 16'd1;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[7][7:0] = 8'hFE;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);
		h = good_frame(8'd6, 16'h0F0F, 16'hF0F0);
		h.addr[3][7:0] = 8'd7;
		add_row(h, 1'b1, VERDICT_DROP, CAUSE_ERRSUM);

		// Hold reset low, then release it at a falling edge.
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			offer_frame(directed_rows[i]);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			ofr = '0;
			ofr.hdr = random_frame();
			offer_frame(ofr);
		end
		s_axis_tvalid <= 1'b0;

		// Drain: wait for every expected verdict, then a pipeline's worth more.
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 8) @(negedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("tb_ipv6_source_address_gate_filter OK");
		end else begin
			$display("tb_ipv6_source_address_gate_filter NOT OK");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/sagf_pkg.sv
hdl/sagf_front.sv
hdl/sagf_cell.sv
hdl/ipv6_source_address_gate_filter.sv
bench/tb_ipv6_source_address_gate_filter.sv
